// File: design/dpc_pkg.sv
// Package for the debounced pulse counter: widths, reset values, field
// positions on the stream words, and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dpc_pkg;

  // Tick time, advanced on each processed sample; interval arithmetic wraps at this width.
  localparam int TimeW     = 32;
  localparam int DebounceW = 16;
  localparam int CountW    = 16;
  localparam int MinW      = 32;

  localparam logic [DebounceW-1:0] DebounceReset = DebounceW'(1000);
  localparam logic [CountW-1:0]    CountMax      = '1;
  localparam logic [MinW-1:0]      MinMax        = '1;

  // Input word: pin_level, clear_count, clear_minimum from bit 0 up.
  localparam int InFieldW  = 3;
  localparam int InDataW   = ((InFieldW + 7) / 8) * 8;
  localparam int InPinBit  = 0;
  localparam int InClrCnt  = 1;
  localparam int InClrMin  = 2;

  // Output word: pulse_count, min_interval, min_valid from bit 0 up.
  localparam int OutFieldW = CountW + MinW + 1;
  localparam int OutDataW  = ((OutFieldW + 7) / 8) * 8;

  // Accepted low level from the debouncer, with the time of its leading edge.
  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] edge_time;
  } pulse_t;

  // One result word before packing.
  typedef struct packed {
    logic              min_valid;
    logic [MinW-1:0]   min_interval;
    logic [CountW-1:0] pulse_count;
  } result_t;

endpackage

`default_nettype wire

// File: design/dpc_debounce.sv
// Debouncer: tick time, previous sample, stable level and the countdown that
// qualifies a level change. Holds the debounce_ticks register. Uses dpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpc_debounce
  import dpc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [DebounceW-1:0] cfg_wdata_i,
  input  wire logic                 step_i,
  input  wire logic                 pin_i,
  output pulse_t                    pulse_o
);

  logic [DebounceW-1:0] deb_ticks_q;
  logic [TimeW-1:0]     tick_q, tick_d;
  logic                 prev_q, prev_d;
  logic                 stable_q, stable_d;
  logic [DebounceW-1:0] cd_q, cd_d;
  logic                 active_q, active_d;
  logic [TimeW-1:0]     edge_q, edge_d;
  logic [DebounceW-1:0] load_val;
  logic [DebounceW-1:0] cd_dec;
  logic                 fire;

  // A zero setting behaves as one tick.
  assign load_val = (deb_ticks_q == '0) ? DebounceW'(1) : deb_ticks_q;
  assign cd_dec   = cd_q - DebounceW'(1);

  always_comb begin
    tick_d   = tick_q;
    prev_d   = prev_q;
    stable_d = stable_q;
    cd_d     = cd_q;
    active_d = active_q;
    edge_d   = edge_q;
    fire     = 1'b0;
    if (step_i) begin
      tick_d = tick_q + TimeW'(1);
      prev_d = pin_i;
      if (pin_i != prev_q) begin
        if (pin_i == stable_q) begin
          active_d = 1'b0;
          cd_d     = '0;
        end else begin
          edge_d   = tick_q;
          cd_d     = load_val;
          active_d = 1'b1;
        end
      end else if (active_q) begin
        cd_d = cd_dec;
        if (cd_dec == '0) begin
          active_d = 1'b0;
          stable_d = pin_i;
          fire     = 1'b1;
        end
      end
    end
  end

  // Only an accepted low level counts; edge_q is unchanged on a firing tick.
  assign pulse_o.valid     = fire && !pin_i;
  assign pulse_o.edge_time = edge_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      deb_ticks_q <= DebounceReset;
      tick_q      <= '0;
      prev_q      <= 1'b1;
      stable_q    <= 1'b1;
      cd_q        <= '0;
      active_q    <= 1'b0;
      edge_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        deb_ticks_q <= cfg_wdata_i;
      end
      tick_q   <= tick_d;
      prev_q   <= prev_d;
      stable_q <= stable_d;
      cd_q     <= cd_d;
      active_q <= active_d;
      edge_q   <= edge_d;
    end
  end

  // A running countdown never sits at zero; it would never fire.
  a_cd_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cd_q != '0))
    else $error("countdown active at zero");

endmodule

`default_nettype wire

// File: design/dpc_stats.sv
// Pulse statistics: saturating pulse count, last pulse edge time and the
// smallest interval between counted pulse edges. Uses dpc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dpc_stats
  import dpc_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    step_i,
  input  wire pulse_t  pulse_i,
  input  wire logic    clr_count_i,
  input  wire logic    clr_min_i,
  output result_t      result_o
);

  logic [CountW-1:0] count_q, count_upd;
  logic [MinW-1:0]   min_q, min_upd;
  logic              min_seen_q, min_seen_upd;
  logic [TimeW-1:0]  last_q, last_d;
  logic              last_seen_q, last_seen_d;
  logic [TimeW-1:0]  diff;
  logic [63:0]       diff_wide;
  logic [MinW-1:0]   diff_sat;

  assign diff      = pulse_i.edge_time - last_q;
  assign diff_wide = 64'(diff);
  assign diff_sat  = (diff_wide > 64'(MinMax)) ? MinMax : diff_wide[MinW-1:0];

  always_comb begin
    count_upd    = count_q;
    min_upd      = min_q;
    min_seen_upd = min_seen_q;
    last_d       = last_q;
    last_seen_d  = last_seen_q;
    if (step_i && pulse_i.valid) begin
      if (count_q != CountMax) begin
        count_upd = count_q + CountW'(1);
      end
      // The first pulse only records its edge; a zero interval is ignored.
      if (last_seen_q && (diff != '0)) begin
        if (!min_seen_q || (diff_sat < min_q)) begin
          min_upd      = diff_sat;
          min_seen_upd = 1'b1;
        end
      end
      last_d      = pulse_i.edge_time;
      last_seen_d = 1'b1;
    end
  end

  assign result_o.pulse_count  = count_upd;
  assign result_o.min_interval = min_seen_upd ? min_upd : '0;
  assign result_o.min_valid    = min_seen_upd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      min_q       <= '0;
      min_seen_q  <= 1'b0;
      last_q      <= '0;
      last_seen_q <= 1'b0;
    end else begin
      count_q     <= (step_i && clr_count_i) ? '0 : count_upd;
      min_q       <= (step_i && clr_min_i) ? '0 : min_upd;
      min_seen_q  <= (step_i && clr_min_i) ? 1'b0 : min_seen_upd;
      last_q      <= last_d;
      last_seen_q <= last_seen_d;
    end
  end

  // A minimum only exists once a previous pulse edge has been recorded.
  a_min_needs_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    min_seen_q |-> last_seen_q)
    else $error("minimum interval without a recorded pulse");

  a_min_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !min_seen_q |-> (min_q == '0))
    else $error("stale minimum while not valid");

endmodule

`default_nettype wire

// File: design/debounced_pulse_counter_min_interval.sv
// Top level of the debounced pulse counter: input word register, debouncer,
// statistics and output word register. Uses dpc_pkg, dpc_debounce, dpc_stats.
//
//  Channel  Direction  Signals                       Contents
//  s_axis   in         tvalid tready tdata[7:0]      one pin sample per tick
//  m_axis   out        tvalid tready tdata[55:0]     count and minimum per tick
//  cfg      in         cfg_we_i cfg_wdata_i[15:0]    debounce_ticks
//
// Each word passes through the input register, then through the debounce and
// statistics logic into the output register.
// One word is accepted per cycle while the output side keeps up; the input
// register and the output register together form the only buffering.
// Reset clears the valid flags and all counter state; debounce_ticks returns to 1000.
// A stalled output holds its word and the input register holds one more.
`timescale 1ns / 1ps
`default_nettype none

module debounced_pulse_counter_min_interval
  import dpc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [DebounceW-1:0] cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  output      logic                 s_axis_tready,
  // [0] pin_level, [1] clear_count, [2] clear_minimum, [7:3] zero
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  output      logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [15:0] pulse_count, [47:16] min_interval, [48] min_valid, [55:49] zero
  output      logic [OutDataW-1:0]  m_axis_tdata
);

  logic                in_valid_q;
  logic [InFieldW-1:0] in_data_q;
  logic                out_valid_q;
  result_t             out_res_q;
  logic                advance;
  logic                step;
  pulse_t              pulse;
  result_t             result;

  assign advance       = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && advance;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        in_valid_q <= 1'b1;
      end else if (step) begin
        in_valid_q <= 1'b0;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata[InFieldW-1:0];
    end
    if (step) begin
      out_res_q <= result;
    end
  end

  dpc_debounce u_debounce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .pin_i       (in_data_q[InPinBit]),
    .pulse_o     (pulse)
  );

  dpc_stats u_stats (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .pulse_i     (pulse),
    .clr_count_i (in_data_q[InClrCnt]),
    .clr_min_i   (in_data_q[InClrMin]),
    .result_o    (result)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - OutFieldW)'(0), out_res_q};

  // The input register never drops a word that has not gone through.
  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> in_valid_q)
    else $error("input word lost while output stalled");

  a_ready_means_room : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (in_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// File: dv/dpc_result_monitor.sv
// Result monitor for the debounced pulse counter: watches both stream channels
// and the configuration port, predicts each output word and compares it.
// Depends on dpc_pkg.
`timescale 1ns / 1ps

module dpc_result_monitor
  import dpc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [DebounceW-1:0] cfg_wdata_i,
  input  wire logic                 s_axis_tvalid,
  input  wire logic                 s_axis_tready,
  // [0] pin_level, [1] clear_count, [2] clear_minimum, [7:3] zero
  input  wire logic [InDataW-1:0]   s_axis_tdata,
  input  wire logic                 m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [15:0] pulse_count, [47:16] min_interval, [48] min_valid, [55:49] zero
  input  wire logic [OutDataW-1:0]  m_axis_tdata,
  output int                        mismatches_o,
  output int                        outstanding_o,
  output int                        compared_o,
  output int                        pulses_o
);

  // Shadow copy of the block's state, updated once per accepted input word.
  logic [DebounceW-1:0] debounce_ticks;
  logic [TimeW-1:0]     now_ticks;
  logic [TimeW-1:0]     edge_stamp;
  logic [TimeW-1:0]     last_pulse_stamp;
  logic                 prev_pin;
  logic                 stable_pin;
  logic                 timing;
  logic [DebounceW-1:0] remaining;
  logic                 pulse_seen;
  logic [CountW-1:0]    pulse_total;
  logic [MinW-1:0]      min_gap;
  logic                 min_seen;

  result_t expected_counts[$];
  int      mismatches;
  int      compared;
  int      pulses;

  function automatic result_t step_pulse_counter(input logic pin, input logic clr_count,
                                                 input logic clr_min);
    result_t          res;
    logic [TimeW-1:0] gap;
    if (pin != prev_pin) begin
      if (pin == stable_pin) begin
        timing    = 1'b0;
        remaining = '0;
      end else begin
        edge_stamp = now_ticks;
        remaining  = (debounce_ticks == '0) ? DebounceW'(1) : debounce_ticks;
        timing     = 1'b1;
      end
    end else if (timing) begin
      remaining = remaining - 1'b1;
      if (remaining == '0) begin
        timing     = 1'b0;
        stable_pin = pin;
        if (!pin) begin
          pulses++;
          if (pulse_total != CountMax) pulse_total = pulse_total + 1'b1;
          if (pulse_seen) begin
            gap = edge_stamp - last_pulse_stamp;
            // A gap wider than the minimum field saturates; a zero gap is skipped.
            if (gap > TimeW'(MinMax)) gap = TimeW'(MinMax);
            if (gap != '0 && (!min_seen || MinW'(gap) < min_gap)) begin
              min_gap  = MinW'(gap);
              min_seen = 1'b1;
            end
          end
          last_pulse_stamp = edge_stamp;
          pulse_seen       = 1'b1;
        end
      end
    end
    prev_pin = pin;

    res.pulse_count  = pulse_total;
    res.min_interval = min_seen ? min_gap : '0;
    res.min_valid    = min_seen;

    if (clr_count) pulse_total = '0;
    if (clr_min) begin
      min_gap  = '0;
      min_seen = 1'b0;
    end
    now_ticks = now_ticks + 1'b1;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t got;
    result_t want;
    if (!rst_ni) begin
      debounce_ticks   = DebounceReset;
      now_ticks        = '0;
      edge_stamp       = '0;
      last_pulse_stamp = '0;
      prev_pin         = 1'b1;
      stable_pin       = 1'b1;
      timing           = 1'b0;
      remaining        = '0;
      pulse_seen       = 1'b0;
      pulse_total      = '0;
      min_gap          = '0;
      min_seen         = 1'b0;
      expected_counts.delete();
      mismatches       = 0;
      compared         = 0;
      pulses           = 0;
    end else begin
      if (cfg_we_i) debounce_ticks = cfg_wdata_i;
      if (s_axis_tvalid && s_axis_tready) begin
        expected_counts.push_back(step_pulse_counter(s_axis_tdata[InPinBit],
                                                     s_axis_tdata[InClrCnt],
                                                     s_axis_tdata[InClrMin]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata[OutFieldW-1:0]);
        if (expected_counts.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: word arrived with nothing pending: count %0d min %0d valid %0b",
                     $realtime, got.pulse_count, got.min_interval, got.min_valid);
        end else begin
          want = expected_counts.pop_front();
          compared++;
          if (got.pulse_count != want.pulse_count || got.min_interval != want.min_interval ||
              got.min_valid != want.min_valid) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: word %0d expected count %0d min %0d valid %0b, got %0d %0d %0b",
                       $realtime, compared, want.pulse_count, want.min_interval,
                       want.min_valid, got.pulse_count, got.min_interval, got.min_valid);
          end
        end
      end
    end
    mismatches_o  <= mismatches;
    outstanding_o <= expected_counts.size();
    compared_o    <= compared;
    pulses_o      <= pulses;
  end

endmodule

// File: dv/debounced_pulse_counter_min_interval_test.sv
// Top of the pulse counter testbench: clock, reset, stimulus on the input
// stream, back-pressure on the output stream and the verdict.
// Depends on dpc_pkg, debounced_pulse_counter_min_interval and dpc_result_monitor.
`timescale 1ns / 1ps

module debounced_pulse_counter_min_interval_test;
  import dpc_pkg::*;

  localparam int HoldCycles     = 80;
  localparam int BurstPulses    = 25;
  localparam int PhaseWords     = 180;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [DebounceW-1:0] cfg_wdata_i   = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic                 m_axis_tready = 1'b0;
  logic                 s_axis_tready;
  logic                 m_axis_tvalid;
  logic [OutDataW-1:0]  m_axis_tdata;

  int mismatches;
  int outstanding;
  int compared;
  int pulses;

  bit                   idle_on      = 1'b1;
  bit                   hold_request = 1'b0;
  bit                   line_level   = 1'b1;
  logic [DebounceW-1:0] debounce_now = DebounceReset;
  int                   words_sent   = 0;

  debounced_pulse_counter_min_interval u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  dpc_result_monitor u_monitor (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .compared_o    (compared),
    .pulses_o      (pulses)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Output side: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_request = 1'b0;
      end else begin
        m_axis_tready <= !(idle_on && $urandom_range(99) < 24);
      end
    end
  end

  function automatic bit rare_flag();
    return $urandom_range(99) < 6;
  endfunction

  // Presents one word and returns at the edge where it is taken.
  task automatic send_word(input bit pin, input bit clr_count, input bit clr_min);
    logic [InDataW-1:0] word;
    word           = '0;
    word[InPinBit] = pin;
    word[InClrCnt] = clr_count;
    word[InClrMin] = clr_min;
    while (idle_on && $urandom_range(99) < 24) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= word;
    do @(posedge clk_i); while (!s_axis_tready);
    line_level = pin;
    words_sent++;
  endtask

  // The register is only written once the pipeline has drained.
  task automatic set_debounce(input logic [DebounceW-1:0] ticks);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= ticks;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    debounce_now  = ticks;
  endtask

  // Mostly alternating level runs, long enough to be accepted or short enough
  // to be rejected as glitches, mixed with single random samples.
  task automatic run_random_phase(input int words);
    int sent;
    int run_len;
    int span;
    bit pin;
    sent = 0;
    span = (debounce_now == '0) ? 1 : int'(debounce_now);
    while (sent < words) begin
      if ($urandom_range(99) < 20) begin
        send_word(1'($urandom_range(1)), rare_flag(), rare_flag());
        sent++;
      end else begin
        pin = !line_level;
        if ($urandom_range(99) < 25) run_len = $urandom_range(span, 1);
        else run_len = span + 1 + $urandom_range(3);
        repeat (run_len) begin
          send_word(pin, rare_flag(), rare_flag());
          sent++;
        end
      end
    end
  endtask

  // Opening sequence at the shortest debounce, as {clear_minimum, clear_count, pin}:
  // first pulse, a measured interval, a rejected glitch, each clear alone and
  // both together, and a pulse abandoned before it settles high.
  localparam logic [2:0] Opening [22] = '{
    3'b000, 3'b000, 3'b001, 3'b001, 3'b000, 3'b000, 3'b011, 3'b001,
    3'b000, 3'b001, 3'b000, 3'b000, 3'b101, 3'b001, 3'b000, 3'b000,
    3'b111, 3'b000, 3'b000, 3'b001, 3'b001, 3'b111
  };

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A debounce of zero behaves as one.
    set_debounce('0);
    foreach (Opening[i]) send_word(Opening[i][0], Opening[i][1], Opening[i][2]);

    // Longest debounce: a low level that is dropped long before it settles.
    set_debounce('1);
    repeat (30) send_word(1'b0, 1'b0, 1'b0);
    repeat (5) send_word(1'b1, 1'b0, 1'b0);

    // A burst of short pulses with no idling on either side.
    set_debounce(DebounceW'(1));
    idle_on = 1'b0;
    repeat (BurstPulses) begin
      repeat (2) send_word(1'b0, 1'b0, 1'b0);
      repeat (2) send_word(1'b1, 1'b0, 1'b0);
    end
    idle_on = 1'b1;

    set_debounce(DebounceW'(2));
    hold_request = 1'b1;
    run_random_phase(PhaseWords);
    set_debounce(DebounceW'(5));
    run_random_phase(PhaseWords);
    set_debounce(DebounceW'(1));
    run_random_phase(PhaseWords);
    set_debounce(DebounceW'(13));
    run_random_phase(PhaseWords);
    set_debounce(DebounceW'($urandom_range(20, 1)));
    run_random_phase(PhaseWords);

    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d words and checked %0d results, %0d debounced low pulses in all,",
             words_sent, compared, pulses);
    $display("with debounce from 0 to 65535, a burst with no idling and a long output stall.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
